[rtl/page_table_map_and_translate_assert.svh]
// Assertion macros shared by the page table engine.
`ifndef PAGE_TABLE_MAP_AND_TRANSLATE_ASSERT_SVH
`define PAGE_TABLE_MAP_AND_TRANSLATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTMT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/ptmt_pkg.sv]
`timescale 1ns / 1ps
package ptmt_pkg;
  localparam int TABLE_SLOTS       = 16;
  localparam int ENTRIES_PER_TABLE = 1024;
  localparam int DIR_ENTRIES       = 1024;
  localparam int IDX_W             = 10;
  localparam int OFS_W             = 12;
  localparam int SLOT_W            = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int USED_W            = $clog2(TABLE_SLOTS + 1);
  localparam int DIR_W             = SLOT_W + 1;
  localparam int TABLE_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int TADDR_W           = $clog2(TABLE_DEPTH);

  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [1:0] STATUS_MAPPED  = 2'd0;
  localparam logic [1:0] STATUS_FAILED  = 2'd1;
  localparam logic [1:0] STATUS_XLATED  = 2'd2;
  localparam logic [1:0] STATUS_NOTMAP  = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
    logic [19:0] table_frame;
    logic        table_frame_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys_out;
  } out_item_t;

  typedef struct packed {
    logic             is_map;
    logic [IDX_W-1:0] di;
    logic [IDX_W-1:0] ti;
    logic [31:0]      entry;
    logic [OFS_W-1:0] offset;
    logic             frame_ok;
  } cmd_t;
endpackage

[rtl/ptmt_ram.sv]
`timescale 1ns / 1ps
module ptmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/ptmt_front.sv]
`timescale 1ns / 1ps
module ptmt_front import ptmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);
  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;

  always_comb begin
    cls.is_map   = (item.opcode == OP_MAP);
    cls.di       = item.virt_addr[31:22];
    cls.ti       = item.virt_addr[21:12];
    cls.entry    = {item.phys_addr[31:12], item.page_flags};
    cls.offset   = item.virt_addr[11:0];
    cls.frame_ok = item.table_frame_ok;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
    end
    if (cmd_pop && cmd_valid) begin
      rp_nxt = ~rp_r;
    end
    cnt_nxt = cnt_r + {1'b0, (push && !full)} - {1'b0, (cmd_pop && cmd_valid)};
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[rtl/ptmt_back.sv]
`timescale 1ns / 1ps
`include "page_table_map_and_translate_assert.svh"
module ptmt_back import ptmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      clearing,
  output logic      out_empty,
  output out_item_t out_item,
  input  logic      out_pop
);
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIR  = 3'd2;
  localparam logic [2:0] ST_TCLR = 3'd3;
  localparam logic [2:0] ST_TWR  = 3'd4;
  localparam logic [2:0] ST_TRD  = 3'd5;
  localparam logic [2:0] ST_RESP = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  cmd_t              cmd_r, cmd_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_r, out_nxt;
  logic              outv_r, outv_nxt;

  logic               dir_we;
  logic [IDX_W-1:0]   dir_addr;
  logic [DIR_W-1:0]   dir_wdata, dir_rdata;
  logic               tab_we;
  logic [TADDR_W-1:0] tab_addr;
  logic [31:0]        tab_wdata, tab_rdata;
  logic               present;
  logic [SLOT_W-1:0]  dslot;

  ptmt_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
  );

  ptmt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .addr(tab_addr), .wdata(tab_wdata), .rdata(tab_rdata)
  );

  assign present   = dir_rdata[DIR_W-1];
  assign dslot     = dir_rdata[SLOT_W-1:0];
  assign clearing  = (state_r == ST_CLR);
  assign out_empty = !outv_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    slot_nxt  = slot_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    outv_nxt  = outv_r && !out_pop;
    cmd_pop   = 1'b0;
    dir_we    = 1'b0;
    dir_addr  = cmd_r.di;
    dir_wdata = {1'b1, used_r[SLOT_W-1:0]};
    tab_we    = 1'b0;
    tab_addr  = TADDR_W'({slot_r, cmd_r.ti});
    tab_wdata = cmd_r.entry;
    unique case (state_r)
      ST_CLR: begin
        dir_we    = 1'b1;
        dir_addr  = cnt_r;
        dir_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          dir_addr  = cmd.di;
          state_nxt = ST_DIR;
        end
      end
      ST_DIR: begin
        if (!cmd_r.is_map) begin
          if (!present) begin
            res_nxt   = '{status: STATUS_NOTMAP, phys_out: '0};
            state_nxt = ST_RESP;
          end else begin
            slot_nxt  = dslot;
            tab_addr  = TADDR_W'({dslot, cmd_r.ti});
            state_nxt = ST_TRD;
          end
        end else if (present) begin
          tab_we    = 1'b1;
          tab_addr  = TADDR_W'({dslot, cmd_r.ti});
          res_nxt   = '{status: STATUS_MAPPED, phys_out: '0};
          state_nxt = ST_RESP;
        end else if (!cmd_r.frame_ok || used_r == USED_W'(TABLE_SLOTS)) begin
          res_nxt   = '{status: STATUS_FAILED, phys_out: '0};
          state_nxt = ST_RESP;
        end else begin
          dir_we    = 1'b1;
          slot_nxt  = used_r[SLOT_W-1:0];
          used_nxt  = used_r + 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_TCLR;
        end
      end
      ST_TCLR: begin
        tab_we    = 1'b1;
        tab_addr  = TADDR_W'({slot_r, cnt_r});
        tab_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = ST_TWR;
        end
      end
      ST_TWR: begin
        tab_we    = 1'b1;
        res_nxt   = '{status: STATUS_MAPPED, phys_out: '0};
        state_nxt = ST_RESP;
      end
      ST_TRD: begin
        if (!tab_rdata[0]) begin
          res_nxt = '{status: STATUS_NOTMAP, phys_out: '0};
        end else begin
          res_nxt = '{status: STATUS_XLATED, phys_out: {tab_rdata[31:12], cmd_r.offset}};
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!outv_r || out_pop) begin
          out_nxt   = res_r;
          outv_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    slot_r <= slot_nxt;
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      used_r  <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      outv_r  <= outv_nxt;
    end
  end

  `PTMT_ASSERT(a_used_bound, clk, rst_n, used_r <= USED_W'(TABLE_SLOTS), "table pool overrun")
  `PTMT_ASSERT(a_pop_idle, clk, rst_n, cmd_pop |-> (state_r == ST_IDLE && cmd_valid), "bad pop")
  `PTMT_ASSERT(a_tclr_exit, clk, rst_n, state_r == ST_TCLR |=> (state_r == ST_TCLR || state_r == ST_TWR), "bad clear exit")
endmodule

[rtl/page_table_map_and_translate.sv]
`timescale 1ns / 1ps
// Channel   Ports                          Payload
// input     in_push, in_full, in_item      in_item_t
// result    out_empty, out_pop, out_item   out_item_t
//
// When the engine is free, a translate passes the directory, table read and response states on its
// way to the result ports, and a map to an existing table the directory and response states.
// A map that allocates a table first clears all 1024 entries of that table, then writes its entry.
// After reset all 1024 directory entries are cleared while in_full is high.
// The input queue holds two transactions; the result register stalls the engine when full.
module page_table_map_and_translate import ptmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);
  logic q_full, cmd_valid, cmd_pop, clearing;
  cmd_t cmd;

  assign in_full = q_full || clearing;

  ptmt_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push && !clearing), .item(in_item),
    .full(q_full), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  ptmt_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .clearing(clearing), .out_empty(out_empty), .out_item(out_item), .out_pop(out_pop)
  );
endmodule
